### rtl/gmfmm_pkg.sv
// shared constants for the group mean filter with min and max
`timescale 1ns / 1ps

package gmfmm_pkg;

    localparam int CFG_W      = 6;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CFG_W-1:0] GROUP_SIZE_RESET = CFG_W'(5);

    // register index, taken from paddr above the byte offset
    localparam logic REG_GROUP_SIZE = 1'b0;

endpackage

### rtl/gmfmm_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module gmfmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/group_mean_filter_min_max_unit.sv
// top level of the group mean filter with min and max
`timescale 1ns / 1ps
// a sample that leaves its group open is taken and gives no result
// a closing sample starts a replay: ST_FIRST_READ primes the buffer read, then ST_CHECK
// steps through the buffered samples via the single ram read port, holding on a selected
// sample while the output is busy, then the summary
// reset clears control, running statistics and output valid, and sets group_size to 5;
// the sample buffer is not cleared

module group_mean_filter_min_max_unit #(
    parameter int MAX_GROUP   = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [gmfmm_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [gmfmm_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [gmfmm_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                  pready,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [SAMPLE_BITS-1:0]         s_sample,
    input  logic                                  s_final_sample,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_is_summary,
    output logic signed [SAMPLE_BITS-1:0]         m_picked_value,
    output logic signed [SAMPLE_BITS-1:0]         m_group_max,
    output logic signed [SAMPLE_BITS-1:0]         m_group_min,
    output logic                                  m_run_end
);

    import gmfmm_pkg::*;

    localparam int CNT_W  = $clog2(MAX_GROUP + 1);
    localparam int AW     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int PROD_W = SAMPLE_BITS + CNT_W + 1;
    localparam int EW     = CNT_W + CFG_W;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_FIRST_READ,
        ST_CHECK,
        ST_SUMMARY
    } state_t;

    state_t                    state_reg, state_next;
    logic [CFG_W-1:0]          gsize_reg, gsize_next;
    logic [CNT_W-1:0]          fill_reg, fill_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [SAMPLE_BITS-1:0] max_reg, max_next;
    logic signed [SAMPLE_BITS-1:0] min_reg, min_next;

    logic                      m_valid_reg, m_valid_next;
    logic                      summ_reg, summ_next;
    logic signed [SAMPLE_BITS-1:0] pick_reg, pick_next;
    logic signed [SAMPLE_BITS-1:0] omax_reg, omax_next;
    logic signed [SAMPLE_BITS-1:0] omin_reg, omin_next;
    logic                      end_reg, end_next;

    logic                      ram_we;
    logic                      ram_re;
    logic [AW-1:0]             ram_raddr;
    logic signed [SAMPLE_BITS-1:0] ram_rdata;

    logic                      cfg_wr;
    logic [EW-1:0]             gsize_ext;
    logic [EW-1:0]             eff_size;
    logic [CNT_W-1:0]          fill_inc;
    logic [CNT_W-1:0]          idx_inc;
    logic                      closes;
    logic                      out_free;
    logic signed [PROD_W-1:0]  prod;
    logic                      selected;
    logic                      last_entry;

    gmfmm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_GROUP)
    ) u_buf (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (s_sample),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_GROUP_SIZE);
    assign gsize_next = cfg_wr ? pwdata[CFG_W-1:0] : gsize_reg;
    assign prdata = (paddr[2] == REG_GROUP_SIZE) ? APB_DATA_W'(gsize_reg) : '0;

    // effective group size
    assign gsize_ext = EW'(gsize_reg);
    always_comb begin
        if (gsize_ext == '0) begin
            eff_size = EW'(1);
        end else if (gsize_ext > EW'(MAX_GROUP)) begin
            eff_size = EW'(MAX_GROUP);
        end else begin
            eff_size = gsize_ext;
        end
    end

    assign fill_inc   = fill_reg + CNT_W'(1);
    assign idx_inc    = idx_reg + CNT_W'(1);
    assign closes     = s_final_sample || (EW'(fill_inc) >= eff_size);
    assign out_free   = !m_valid_reg || m_ready;
    assign prod       = PROD_W'(ram_rdata) * $signed({1'b0, fill_reg});
    assign selected   = prod >= PROD_W'(sum_reg);
    assign last_entry = (idx_inc == fill_reg);

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        idx_next     = idx_reg;
        sum_next     = sum_reg;
        max_next     = max_reg;
        min_next     = min_reg;
        m_valid_next = m_valid_reg && !m_ready;
        summ_next    = summ_reg;
        pick_next    = pick_reg;
        omax_next    = omax_reg;
        omin_next    = omin_reg;
        end_next     = end_reg;
        s_ready      = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = idx_reg[AW-1:0];

        unique case (state_reg)
            ST_COLLECT: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ram_we    = 1'b1;
                    fill_next = fill_inc;
                    sum_next  = sum_reg + SUM_W'(s_sample);
                    if (fill_reg == '0) begin
                        max_next = s_sample;
                        min_next = s_sample;
                    end else begin
                        if (s_sample > max_reg) begin
                            max_next = s_sample;
                        end
                        if (s_sample < min_reg) begin
                            min_next = s_sample;
                        end
                    end
                    if (closes) begin
                        idx_next   = '0;
                        state_next = ST_FIRST_READ;
                    end
                end
            end
            ST_FIRST_READ: begin
                ram_re     = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (!selected || out_free) begin
                    if (selected) begin
                        m_valid_next = 1'b1;
                        summ_next    = 1'b0;
                        pick_next    = ram_rdata;
                        omax_next    = '0;
                        omin_next    = '0;
                        end_next     = 1'b0;
                    end
                    if (last_entry) begin
                        state_next = ST_SUMMARY;
                    end else begin
                        idx_next  = idx_inc;
                        ram_re    = 1'b1;
                        ram_raddr = idx_inc[AW-1:0];
                    end
                end
            end
            ST_SUMMARY: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    summ_next    = 1'b1;
                    pick_next    = '0;
                    omax_next    = max_reg;
                    omin_next    = min_reg;
                    end_next     = 1'b1;
                    fill_next    = '0;
                    sum_next     = '0;
                    max_next     = '0;
                    min_next     = '0;
                    state_next   = ST_COLLECT;
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_COLLECT;
            gsize_reg   <= GROUP_SIZE_RESET;
            fill_reg    <= '0;
            idx_reg     <= '0;
            sum_reg     <= '0;
            max_reg     <= '0;
            min_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            gsize_reg   <= gsize_next;
            fill_reg    <= fill_next;
            idx_reg     <= idx_next;
            sum_reg     <= sum_next;
            max_reg     <= max_next;
            min_reg     <= min_next;
            m_valid_reg <= m_valid_next;
        end
        summ_reg <= summ_next;
        pick_reg <= pick_next;
        omax_reg <= omax_next;
        omin_reg <= omin_next;
        end_reg  <= end_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_is_summary   = summ_reg;
    assign m_picked_value = pick_reg;
    assign m_group_max    = omax_reg;
    assign m_group_min    = omin_reg;
    assign m_run_end      = end_reg;

endmodule
